// ===== rtl/core/mspg_pkg.sv =====
// package for the multiplexed servo pulse generator
// holds payload structs, op codes, register indexes and widths; no dependencies
package mspg_pkg;

  localparam int NUM_SERVOS = 8;
  localparam int PHASE_W    = $clog2(NUM_SERVOS + 1);
  localparam int SERVO_IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int PIN_W      = 8;
  localparam int WIDTH_W    = 8;
  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 2'd2;

  localparam logic [TICKS_W-1:0] FRAME_TICKS_RST = 16'd1152;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 8'd0;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST   = 8'hFF;
  localparam logic [TICKS_W-1:0] SUM_SAT         = 16'hFFFF;

  typedef logic [PHASE_W-1:0] phase_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [WIDTH_W-1:0] servo_index;
    logic [WIDTH_W-1:0] width_value;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pins;
    logic [WIDTH_W-1:0] read_data;
  } out_item_t;

  function automatic logic [PIN_W-1:0] pin_bit(phase_t s);
    logic [PIN_W-1:0] b;
    b = '0;
    if (32'(s) < PIN_W) begin
      b = PIN_W'(1) << s;
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/multiplexed_servo_pulse_generator.sv =====
// top level of the multiplexed servo pulse generator: slot timing, width table,
// config registers and output register; depends on mspg_pkg
//
//   channel | signals                         | direction
//   in      | in_valid, in_ready, in_data     | item in (tick, write, read)
//   out     | out_valid, out_ready, out_data  | result out (pins, read_data)
//   cfg     | cfg_we, cfg_index, cfg_data     | register write, no wait
//
// one item per clock while out is not stalled: each transfer updates state and loads
// the output register, so the result appears in the cycle after its input transfer
// in_ready is high whenever the output register is empty or being taken
// reset (rst, synchronous) clears the width table, timing state and config
// a stall on out holds the result and blocks in until it is taken
module multiplexed_servo_pulse_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mspg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mspg_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mspg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mspg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [mspg_pkg::TICKS_W-1:0] frame_ticks;
  logic [mspg_pkg::WIDTH_W-1:0] min_width;
  logic [mspg_pkg::WIDTH_W-1:0] max_width;

  logic [mspg_pkg::WIDTH_W-1:0] widths [mspg_pkg::NUM_SERVOS];
  mspg_pkg::phase_t             phase, phase_next;
  logic [mspg_pkg::TICKS_W-1:0] ticks_left, ticks_left_next;
  logic [mspg_pkg::TICKS_W-1:0] slot_sum, slot_sum_next;
  logic [mspg_pkg::PIN_W-1:0]   pin_levels, pin_levels_next;

  logic                           in_xfer;
  logic                           wr_en;
  logic [mspg_pkg::SERVO_IDX_W-1:0] wr_idx;
  logic [mspg_pkg::WIDTH_W-1:0]   wr_val;
  logic [mspg_pkg::WIDTH_W-1:0]   rd_val;
  logic                           idx_ok;
  logic [mspg_pkg::TICKS_W-1:0]   tl;
  logic [mspg_pkg::TICKS_W-1:0]   tl_dec;
  mspg_pkg::phase_t               next_slot;
  logic [mspg_pkg::WIDTH_W-1:0]   next_w;
  logic [mspg_pkg::WIDTH_W-1:0]   first_w;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign idx_ok   = in_data.servo_index < mspg_pkg::WIDTH_W'(mspg_pkg::NUM_SERVOS);
  assign wr_idx   = in_data.servo_index[mspg_pkg::SERVO_IDX_W-1:0];
  assign tl       = (ticks_left == '0) ? mspg_pkg::TICKS_W'(1) : ticks_left;
  assign tl_dec   = tl - mspg_pkg::TICKS_W'(1);
  assign next_slot = phase + mspg_pkg::PHASE_W'(1);
  assign next_w   = widths[next_slot[mspg_pkg::SERVO_IDX_W-1:0]];
  assign first_w  = widths[0];

  always_comb begin
    phase_next      = phase;
    ticks_left_next = ticks_left;
    slot_sum_next   = slot_sum;
    pin_levels_next = pin_levels;
    wr_en           = 1'b0;
    wr_val          = in_data.width_value;
    rd_val          = '0;
    unique case (in_data.op)
      mspg_pkg::OP_TICK: begin
        ticks_left_next = tl_dec;
        if (32'(phase) < mspg_pkg::NUM_SERVOS) begin
          if (slot_sum != mspg_pkg::SUM_SAT) begin
            slot_sum_next = slot_sum + mspg_pkg::TICKS_W'(1);
          end
          if (tl_dec == '0) begin
            if (32'(next_slot) < mspg_pkg::NUM_SERVOS) begin
              phase_next      = next_slot;
              ticks_left_next = mspg_pkg::TICKS_W'(next_w) + mspg_pkg::TICKS_W'(1);
              pin_levels_next = (next_w != '0) ? mspg_pkg::pin_bit(next_slot) : '0;
            end else begin
              phase_next      = mspg_pkg::PHASE_W'(mspg_pkg::NUM_SERVOS);
              pin_levels_next = '0;
              ticks_left_next = (frame_ticks > slot_sum_next)
                                ? frame_ticks - slot_sum_next : mspg_pkg::TICKS_W'(1);
            end
          end
        end else if (tl_dec == '0) begin
          slot_sum_next   = '0;
          phase_next      = '0;
          ticks_left_next = mspg_pkg::TICKS_W'(first_w) + mspg_pkg::TICKS_W'(1);
          pin_levels_next = (first_w != '0) ? mspg_pkg::pin_bit('0) : '0;
        end
      end
      mspg_pkg::OP_WRITE: begin
        wr_en = idx_ok;
        if (in_data.width_value != '0) begin
          if (wr_val < min_width) begin
            wr_val = min_width;
          end
          if (wr_val > max_width) begin
            wr_val = max_width;
          end
        end
      end
      mspg_pkg::OP_READ: begin
        if (idx_ok) begin
          rd_val = widths[wr_idx];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ticks <= mspg_pkg::FRAME_TICKS_RST;
      min_width   <= mspg_pkg::MIN_WIDTH_RST;
      max_width   <= mspg_pkg::MAX_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mspg_pkg::REG_FRAME_TICKS: frame_ticks <= cfg_data;
        mspg_pkg::REG_MIN_WIDTH:   min_width   <= cfg_data[mspg_pkg::WIDTH_W-1:0];
        mspg_pkg::REG_MAX_WIDTH:   max_width   <= cfg_data[mspg_pkg::WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mspg_pkg::NUM_SERVOS; i++) begin
        widths[i] <= '0;
      end
      phase      <= '0;
      ticks_left <= mspg_pkg::TICKS_W'(1);
      slot_sum   <= '0;
      pin_levels <= '0;
    end else if (in_xfer) begin
      if (wr_en) begin
        widths[wr_idx] <= wr_val;
      end
      phase      <= phase_next;
      ticks_left <= ticks_left_next;
      slot_sum   <= slot_sum_next;
      pin_levels <= pin_levels_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data.pins      <= pin_levels_next;
      out_data.read_data <= rd_val;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    32'(phase) <= mspg_pkg::NUM_SERVOS)
    else $error("phase beyond idle");

  a_idle_pins_low: assert property (@(posedge clk) disable iff (rst)
    32'(phase) == mspg_pkg::NUM_SERVOS |-> pin_levels == '0)
    else $error("pin high during idle phase");

  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pin_levels))
    else $error("more than one pin high");

  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    ticks_left != '0)
    else $error("ticks_left reached zero");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
